### rtl/rnbr_pkg.sv
// Shared widths, codes, types and the box-fit test for the region lookup block.
package rnbr_pkg;

    // Table geometry
    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int NUM_FIELD_W = 5;

    // Coordinate and arithmetic widths
    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int TRIG_W     = 16;
    localparam int FRAC_BITS  = 15;
    localparam int PROD_W     = DIFF_W + TRIG_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int ROT_W      = ACC_W - FRAC_BITS;
    localparam int MAG_W      = ROT_W + 1;
    localparam int SIDE_W     = 32;
    localparam int LIMIT_W    = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGIONS = 3'd5;

    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd32767;

    // Operation codes carried in func
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [SIDE_W-1:0]  side_x;
        logic [SIDE_W-1:0]  side_y;
        logic [SIDE_W-1:0]  side_z;
        logic [LIMIT_W-1:0] limit_h;
        logic [LIMIT_W-1:0] limit_v;
    } entry_t;

    // Operands handed to the rotation unit
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
    } rot_in_t;

    // Rotated coordinates returned by the rotation unit
    typedef struct packed {
        logic signed [ROT_W-1:0] vx;
        logic signed [ROT_W-1:0] vy;
    } rot_out_t;

    // Half-length test without rounding: 2*|v| <= side
    function automatic logic fits(input logic signed [ROT_W-1:0] v,
                                  input logic [SIDE_W-1:0] side);
        logic [ROT_W-1:0] mag;
        mag = v[ROT_W-1] ? ROT_W'(-v) : ROT_W'(v);
        return {mag, 1'b0} <= MAG_W'(side);
    endfunction

endpackage

### rtl/rnbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rnbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/rnbr_rotate.sv
// Rotation about the vertical axis on one shared multiplier and accumulator.
module rnbr_rotate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  rnbr_pkg::rot_in_t   opnd,
    output logic                done,
    output rnbr_pkg::rot_out_t  res
);

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_P0,
        RS_P1,
        RS_VX,
        RS_P3,
        RS_VY
    } step_t;

    step_t                                step_reg;
    logic signed [rnbr_pkg::PROD_W-1:0]   prod_reg;
    logic signed [rnbr_pkg::ACC_W-1:0]    acc_reg;
    logic signed [rnbr_pkg::ROT_W-1:0]    vx_reg;
    logic signed [rnbr_pkg::ROT_W-1:0]    vy_reg;

    logic signed [rnbr_pkg::DIFF_W-1:0]   mul_a;
    logic signed [rnbr_pkg::TRIG_W-1:0]   mul_b;
    logic signed [rnbr_pkg::PROD_W-1:0]   prod_next;
    logic signed [rnbr_pkg::ACC_W-1:0]    diff_sum;
    logic signed [rnbr_pkg::ACC_W-1:0]    add_sum;

    // Select multiplier operands: dx*cos, dy*sin, dx*sin, dy*cos
    always_comb
    begin
        mul_a = opnd.dx;
        mul_b = opnd.cos_q;
        unique case (step_reg)
            RS_P1:
            begin
                mul_a = opnd.dy;
                mul_b = opnd.sin_q;
            end
            RS_VX:
            begin
                mul_a = opnd.dx;
                mul_b = opnd.sin_q;
            end
            RS_P3:
            begin
                mul_a = opnd.dy;
                mul_b = opnd.cos_q;
            end
            default:
            begin
                mul_a = opnd.dx;
                mul_b = opnd.cos_q;
            end
        endcase
    end

    assign prod_next = rnbr_pkg::PROD_W'(mul_a) * rnbr_pkg::PROD_W'(mul_b);
    assign diff_sum  = acc_reg - rnbr_pkg::ACC_W'(prod_reg);
    assign add_sum   = acc_reg + rnbr_pkg::ACC_W'(prod_reg);

    // Advance the step sequence and update product, accumulator and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= RS_IDLE;
        end
        else
        begin
            unique case (step_reg)
                RS_IDLE:
                begin
                    if (go)
                    begin
                        step_reg <= RS_P0;
                    end
                end
                RS_P0:
                begin
                    prod_reg <= prod_next;
                    step_reg <= RS_P1;
                end
                RS_P1:
                begin
                    acc_reg  <= rnbr_pkg::ACC_W'(prod_reg);
                    prod_reg <= prod_next;
                    step_reg <= RS_VX;
                end
                RS_VX:
                begin
                    // Arithmetic shift floors toward minus infinity
                    vx_reg   <= rnbr_pkg::ROT_W'(diff_sum >>> rnbr_pkg::FRAC_BITS);
                    prod_reg <= prod_next;
                    step_reg <= RS_P3;
                end
                RS_P3:
                begin
                    acc_reg  <= rnbr_pkg::ACC_W'(prod_reg);
                    prod_reg <= prod_next;
                    step_reg <= RS_VY;
                end
                RS_VY:
                begin
                    vy_reg   <= rnbr_pkg::ROT_W'(add_sum >>> rnbr_pkg::FRAC_BITS);
                    step_reg <= RS_IDLE;
                end
                default:
                begin
                    step_reg <= RS_IDLE;
                end
            endcase
        end
    end

    // Results are valid from the cycle after done
    assign done   = (step_reg == RS_VY);
    assign res.vx = vx_reg;
    assign res.vy = vy_reg;

endmodule

### rtl/rotated_nested_box_region_lookup.sv
// Top level: first-match lookup of a point in a table of rotated nested boxes.
// A load writes one entry and gives no result; busy stays low, so a new transaction
// may start in the next cycle. A query holds busy high until it ends with a done
// strobe: five steps on the shared multiplier, then one RAM read per entry compared,
// at most 16 entries.
// Reset clears the control state and configuration (cosine to 32767); table contents
// stay undefined until loaded. The receiver cannot stall: done lasts one cycle.
module rotated_nested_box_region_lookup (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  func,
    input  logic [rnbr_pkg::IDX_W-1:0]            entry_index,
    input  logic [rnbr_pkg::SIDE_W-1:0]           side_x,
    input  logic [rnbr_pkg::SIDE_W-1:0]           side_y,
    input  logic [rnbr_pkg::SIDE_W-1:0]           side_z,
    input  logic [rnbr_pkg::LIMIT_W-1:0]          limit_horizontal,
    input  logic [rnbr_pkg::LIMIT_W-1:0]          limit_vertical,
    input  logic signed [rnbr_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [rnbr_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [rnbr_pkg::COORD_BITS-1:0] point_z,
    input  logic                                  cfg_wr_en,
    input  logic [rnbr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rnbr_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  done,
    output logic                                  found,
    output logic [rnbr_pkg::IDX_W-1:0]            region_hit,
    output logic [rnbr_pkg::LIMIT_W-1:0]          edge_horizontal,
    output logic [rnbr_pkg::LIMIT_W-1:0]          edge_vertical
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROT,
        ST_SCAN
    } state_t;

    state_t                                   state_reg;

    // Configuration registers
    logic signed [rnbr_pkg::COORD_BITS-1:0]   center_x_reg;
    logic signed [rnbr_pkg::COORD_BITS-1:0]   center_y_reg;
    logic signed [rnbr_pkg::COORD_BITS-1:0]   center_z_reg;
    logic signed [rnbr_pkg::TRIG_W-1:0]       cos_reg;
    logic signed [rnbr_pkg::TRIG_W-1:0]       sin_reg;
    logic [rnbr_pkg::NUM_FIELD_W-1:0]         count_reg;

    // Query operands
    logic signed [rnbr_pkg::DIFF_W-1:0]       dx_reg;
    logic signed [rnbr_pkg::DIFF_W-1:0]       dy_reg;
    logic signed [rnbr_pkg::DIFF_W-1:0]       dz_reg;

    // Scan control
    logic [rnbr_pkg::CNT_W-1:0]               issue_reg;
    logic                                     chk_valid_reg;
    logic [rnbr_pkg::IDX_W-1:0]               chk_idx_reg;

    // Result registers
    logic                                     done_reg;
    logic                                     found_reg;
    logic [rnbr_pkg::IDX_W-1:0]               hit_idx_reg;
    logic [rnbr_pkg::LIMIT_W-1:0]             edge_h_reg;
    logic [rnbr_pkg::LIMIT_W-1:0]             edge_v_reg;

    logic                                     accept;
    logic                                     load_we;
    rnbr_pkg::entry_t                         wr_entry;
    rnbr_pkg::entry_t                         rd_entry;
    logic [rnbr_pkg::CNT_W-1:0]               n_eff;
    logic                                     issue_en;
    logic                                     hit;
    rnbr_pkg::rot_in_t                        rot_in;
    rnbr_pkg::rot_out_t                       rot_out;
    logic                                     rot_go;
    logic                                     rot_done;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign load_we = accept && (func == rnbr_pkg::FUNC_LOAD);

    assign wr_entry = '{side_x:  side_x,
                        side_y:  side_y,
                        side_z:  side_z,
                        limit_h: limit_horizontal,
                        limit_v: limit_vertical};

    // Entry table
    rnbr_ram #(
        .WIDTH ($bits(rnbr_pkg::entry_t)),
        .DEPTH (rnbr_pkg::MAX_REGIONS)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (entry_index),
        .wdata (wr_entry),
        .raddr (issue_reg[rnbr_pkg::IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // Rotation unit
    assign rot_in = '{dx: dx_reg, dy: dy_reg, cos_q: cos_reg, sin_q: sin_reg};
    assign rot_go = (state_reg == ST_PREP);

    rnbr_rotate u_rotate (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (rot_go),
        .opnd  (rot_in),
        .done  (rot_done),
        .res   (rot_out)
    );

    // Clamp the entry count to the table depth
    assign n_eff = (count_reg > rnbr_pkg::NUM_FIELD_W'(rnbr_pkg::MAX_REGIONS)) ?
                   rnbr_pkg::CNT_W'(rnbr_pkg::MAX_REGIONS) :
                   rnbr_pkg::CNT_W'(count_reg);

    assign issue_en = (issue_reg < n_eff);

    // Test the entry read in the previous cycle
    assign hit = chk_valid_reg &&
                 rnbr_pkg::fits(rot_out.vx, rd_entry.side_x) &&
                 rnbr_pkg::fits(rot_out.vy, rd_entry.side_y) &&
                 rnbr_pkg::fits(rnbr_pkg::ROT_W'(dz_reg), rd_entry.side_z);

    // Hold configuration, sequence the query and register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            cos_reg       <= rnbr_pkg::COS_RESET;
            sin_reg       <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            edge_h_reg    <= '0;
            edge_v_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // Configuration writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    rnbr_pkg::CFG_CENTER_X:    center_x_reg <= cfg_data;
                    rnbr_pkg::CFG_CENTER_Y:    center_y_reg <= cfg_data;
                    rnbr_pkg::CFG_CENTER_Z:    center_z_reg <= cfg_data;
                    rnbr_pkg::CFG_ROT_COS:     cos_reg <= cfg_data[rnbr_pkg::TRIG_W-1:0];
                    rnbr_pkg::CFG_ROT_SIN:     sin_reg <= cfg_data[rnbr_pkg::TRIG_W-1:0];
                    rnbr_pkg::CFG_NUM_REGIONS:
                        count_reg <= cfg_data[rnbr_pkg::NUM_FIELD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    // Take the offset from the center on a query
                    if (start && (func == rnbr_pkg::FUNC_QUERY))
                    begin
                        dx_reg    <= rnbr_pkg::DIFF_W'(point_x) -
                                     rnbr_pkg::DIFF_W'(center_x_reg);
                        dy_reg    <= rnbr_pkg::DIFF_W'(point_y) -
                                     rnbr_pkg::DIFF_W'(center_y_reg);
                        dz_reg    <= rnbr_pkg::DIFF_W'(point_z) -
                                     rnbr_pkg::DIFF_W'(center_z_reg);
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (rot_done)
                    begin
                        issue_reg     <= '0;
                        chk_valid_reg <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // Issue one read per cycle, check it in the next
                    if (issue_en)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    chk_valid_reg <= issue_en;
                    chk_idx_reg   <= issue_reg[rnbr_pkg::IDX_W-1:0];

                    if (hit)
                    begin
                        done_reg      <= 1'b1;
                        found_reg     <= 1'b1;
                        hit_idx_reg   <= chk_idx_reg;
                        edge_h_reg    <= rd_entry.limit_h;
                        edge_v_reg    <= rd_entry.limit_v;
                        chk_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                    else if (!issue_en && !chk_valid_reg)
                    begin
                        done_reg    <= 1'b1;
                        found_reg   <= 1'b0;
                        hit_idx_reg <= '0;
                        edge_h_reg  <= '0;
                        edge_v_reg  <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign found           = found_reg;
    assign region_hit      = hit_idx_reg;
    assign edge_horizontal = edge_h_reg;
    assign edge_vertical   = edge_v_reg;

endmodule

### rtl/rnbr_checker.sv
// Port-level checks on the region lookup block, bound to the top level.
module rnbr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          func,
    input logic                          done,
    input logic                          found,
    input logic [rnbr_pkg::IDX_W-1:0]    region_hit,
    input logic [rnbr_pkg::LIMIT_W-1:0]  edge_horizontal,
    input logic [rnbr_pkg::LIMIT_W-1:0]  edge_vertical
);

    // A query transaction occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (func == rnbr_pkg::FUNC_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    // A load transaction finishes at once
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (func == rnbr_pkg::FUNC_LOAD) |=> !busy && !done)
        else $error("load held the block or produced a result");

    // A result ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a query");

    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> (region_hit == '0) && (edge_horizontal == '0) &&
                           (edge_vertical == '0))
        else $error("miss result with nonzero fields");

endmodule

bind rotated_nested_box_region_lookup rnbr_checker u_rnbr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .done            (done),
    .found           (found),
    .region_hit      (region_hit),
    .edge_horizontal (edge_horizontal),
    .edge_vertical   (edge_vertical)
);
